FILE: src/klk_pkg.sv
// Shared definitions for the keypad code lock: code length, key codes,
// status codes and the result record. No dependencies.
`default_nettype none
package klk_pkg;

	localparam int CODE_LENGTH = 4;
	localparam int POS_W = $clog2(CODE_LENGTH + 1);
	localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

	localparam logic [7:0] KEY_ACCESS = 8'd1;
	localparam logic [7:0] KEY_CHANGE = 8'd2;
	localparam logic [7:0] KEY_ENTER  = 8'd13;
	localparam logic [7:0] KEY_CLEAR  = 8'd76;
	localparam logic [7:0] KEY_CANCEL = 8'd67;

	localparam logic [3:0] ST_IGNORED   = 4'd0;
	localparam logic [3:0] ST_TAKEN     = 4'd1;
	localparam logic [3:0] ST_INVALID   = 4'd2;
	localparam logic [3:0] ST_WRONG     = 4'd3;
	localparam logic [3:0] ST_GRANTED   = 4'd4;
	localparam logic [3:0] ST_CLEARED   = 4'd5;
	localparam logic [3:0] ST_CANCELLED = 4'd6;
	localparam logic [3:0] ST_OLD_OK    = 4'd7;
	localparam logic [3:0] ST_CHANGED   = 4'd8;
	localparam logic [3:0] ST_MODE      = 4'd9;

	typedef struct packed {
		logic [3:0] status;
		logic       echo_valid;
		logic [7:0] echo_key;
		logic       open_door;
		logic       store_write;
		logic [1:0] store_index;
		logic [7:0] store_value;
	} klk_result_t;

endpackage
`default_nettype wire

FILE: src/klk_fsm.sv
// Lock sequencer: mode, position, match count and stored code, plus the
// result decode for the key held in the input stage. Uses klk_pkg.
`default_nettype none
module klk_fsm (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire logic [7:0]         key,
	output klk_pkg::klk_result_t    res
);
	import klk_pkg::*;

	localparam logic [2:0] M_MENU     = 3'd0;
	localparam logic [2:0] M_DA_ENTRY = 3'd1;
	localparam logic [2:0] M_DA_WAIT  = 3'd2;
	localparam logic [2:0] M_CP_OLD   = 3'd3;
	localparam logic [2:0] M_OLD_WAIT = 3'd4;
	localparam logic [2:0] M_CP_NEW   = 3'd5;
	localparam logic [2:0] M_CP_DONE  = 3'd6;

	localparam logic [POS_W-1:0] LEN = POS_W'(CODE_LENGTH);

	logic [2:0]       mode_q, mode_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] match_q, match_d;
	logic [7:0]       store_q [CODE_LENGTH];

	logic [POS_W-1:0] pos_inc;
	logic             in_range;
	logic             hit;
	logic             write_en;

	assign pos_inc  = pos_q + POS_W'(1);
	assign in_range = (pos_q < LEN);
	assign hit      = in_range && (store_q[pos_q[IDX_W-1:0]] == key);

	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		match_d  = match_q;
		write_en = 1'b0;
		res      = '0;
		unique case (mode_q)
			M_MENU: begin
				if (key == KEY_ACCESS) begin
					mode_d = M_DA_ENTRY; pos_d = '0; match_d = '0;
					res.status = ST_MODE;
				end else if (key == KEY_CHANGE) begin
					mode_d = M_CP_OLD; pos_d = '0; match_d = '0;
					res.status = ST_MODE;
				end else begin
					res.status = ST_INVALID;
				end
			end
			M_DA_ENTRY: begin
				if (key == KEY_CLEAR) begin
					pos_d = '0; match_d = '0;
					res.status = ST_CLEARED;
				end else if (key == KEY_CANCEL) begin
					mode_d = M_MENU; pos_d = '0; match_d = '0;
					res.status = ST_CANCELLED;
				end else begin
					// enter fills a position without matching or echo
					if (key != KEY_ENTER) begin
						res.echo_valid = 1'b1;
						res.echo_key   = key;
						if (hit) match_d = match_q + POS_W'(1);
					end
					pos_d = pos_inc;
					res.status = ST_TAKEN;
					if (pos_inc >= LEN) mode_d = M_DA_WAIT;
				end
			end
			M_DA_WAIT: begin
				if (key == KEY_ENTER) begin
					pos_d = '0; match_d = '0;
					if (match_q == LEN) begin
						mode_d = M_MENU;
						res.status    = ST_GRANTED;
						res.open_door = 1'b1;
					end else begin
						mode_d = M_DA_ENTRY;
						res.status = ST_WRONG;
					end
				end else if (key == KEY_CLEAR) begin
					mode_d = M_DA_ENTRY; pos_d = '0; match_d = '0;
					res.status = ST_CLEARED;
				end
			end
			M_CP_OLD: begin
				res.echo_valid = 1'b1;
				res.echo_key   = key;
				if (hit) match_d = match_q + POS_W'(1);
				pos_d = pos_inc;
				res.status = ST_TAKEN;
				if (pos_inc >= LEN) mode_d = M_OLD_WAIT;
			end
			M_OLD_WAIT: begin
				if (key == KEY_ENTER) begin
					pos_d = '0; match_d = '0;
					if (match_q == LEN) begin
						mode_d = M_CP_NEW;
						res.status = ST_OLD_OK;
					end else begin
						mode_d = M_CP_OLD;
						res.status = ST_WRONG;
					end
				end
			end
			M_CP_NEW: begin
				write_en          = in_range;
				res.store_write   = 1'b1;
				res.store_index   = 2'(pos_q);
				res.store_value   = key;
				res.echo_valid    = 1'b1;
				res.echo_key      = key;
				res.status        = ST_TAKEN;
				pos_d = pos_inc;
				if (pos_inc >= LEN) mode_d = M_CP_DONE;
			end
			M_CP_DONE: begin
				if (key == KEY_ENTER) begin
					mode_d = M_MENU; pos_d = '0; match_d = '0;
					res.status = ST_CHANGED;
				end
			end
			default: begin
				mode_d = M_MENU; pos_d = '0; match_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_MENU;
			pos_q   <= '0;
			match_q <= '0;
			for (int i = 0; i < CODE_LENGTH; i++) store_q[i] <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			match_q <= match_d;
			if (write_en) store_q[pos_q[IDX_W-1:0]] <= key;
		end
	end

endmodule
`default_nettype wire

FILE: src/keypad_code_lock.sv
// Keypad code lock top level: input stage, sequencer and result register.
// Uses klk_pkg and klk_fsm.
//
// Usage: one key code per input transfer (in_valid high, in_stall low at a
// rising edge). Every key gives exactly one result transfer on the output
// channel (out_valid high, out_stall low): status, echo of the key, a
// door-open pulse on grant, and a store write strobe with index and value
// while a new code is being entered.
// Flow: a key lands in the input stage at its transfer edge; its result
// is registered when the key moves on to the result register, which
// waits while out_stall holds an earlier result. Throughput: one key per
// cycle while out_stall is low; the mode, position and match count update
// at the same edge at which the result is registered.
// Stall: while out_stall holds a result, the next key waits in the input
// stage and in_stall rises only when that stage is full and cannot move.
// Reset (arst_n low): mode returns to the menu, position and match count
// clear, the stored code becomes all zeros and both stages empty.
`default_nettype none
module keypad_code_lock (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] key_code,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [3:0]      status,
	output logic            echo_valid,
	output logic [7:0]      echo_key,
	output logic            open_door,
	output logic            store_write,
	output logic [1:0]      store_index,
	output logic [7:0]      store_value
);
	import klk_pkg::*;

	logic        valid_s1;
	logic [7:0]  key_s1;
	logic        valid_s2;
	klk_result_t res_s2;
	klk_result_t res_c;
	logic        advance;

	// move the held key into the result register when that register is free
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	klk_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.key    (key_s1),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) key_s1 <= key_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res_c;
	end

	assign out_valid   = valid_s2;
	assign status      = res_s2.status;
	assign echo_valid  = res_s2.echo_valid;
	assign echo_key    = res_s2.echo_key;
	assign open_door   = res_s2.open_door;
	assign store_write = res_s2.store_write;
	assign store_index = res_s2.store_index;
	assign store_value = res_s2.store_value;

endmodule
`default_nettype wire
